>>> hw/rtl/bpc_pkg.sv
// Package: shared types, constants and sequencer states for pressure compensation
`timescale 1ns / 1ps
package bpc_pkg;

    localparam int AVERAGE_SHIFT_DEFAULT = 5;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OVERSAMP = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_DIV_START,
        ST_T_DIV_WAIT,
        ST_B6,
        ST_SQ,
        ST_P_X1,
        ST_P_X2,
        ST_B3,
        ST_Q_X1,
        ST_Q_X2,
        ST_B4,
        ST_B7,
        ST_P_DIV_START,
        ST_P_DIV_WAIT,
        ST_C_PP,
        ST_C_X1,
        ST_C_X2,
        ST_DONE,
        ST_OUT
    } seq_state_t;

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

>>> hw/rtl/bpc_if.sv
// Interfaces: item channel and configuration write channel
`timescale 1ns / 1ps
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature;
    logic [31:0] pressure;
    logic [26:0] average_pressure;
    logic        divide_fault;
    modport source (output valid, temperature, pressure, average_pressure, divide_fault,
                    input ready);
    modport sink (input valid, temperature, pressure, average_pressure, divide_fault,
                  output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bpc_divider.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bpc_divider
    import bpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hw/rtl/bpc_config.sv
// Configuration register file
`timescale 1ns / 1ps
module bpc_config
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bpc_cfg_if.sink     cfg,
    output logic [31:0] ac1_ac2,
    output logic [31:0] ac3_ac4,
    output logic [31:0] ac5_ac6,
    output logic [31:0] b1_b2,
    output logic [31:0] mc_md,
    output logic [1:0]  oss
);

    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]  oss_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= '0;
            ac3_ac4_reg <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= 2'd3;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_AC1_AC2:  ac1_ac2_reg <= cfg.data;
                REG_AC3_AC4:  ac3_ac4_reg <= cfg.data;
                REG_AC5_AC6:  ac5_ac6_reg <= cfg.data;
                REG_B1_B2:    b1_b2_reg   <= cfg.data;
                REG_MC_MD:    mc_md_reg   <= cfg.data;
                REG_OVERSAMP: oss_reg     <= cfg.data[1:0];
                default:      ;
            endcase
        end
    end

    assign ac1_ac2 = ac1_ac2_reg;
    assign ac3_ac4 = ac3_ac4_reg;
    assign ac5_ac6 = ac5_ac6_reg;
    assign b1_b2   = b1_b2_reg;
    assign mc_md   = mc_md_reg;
    assign oss     = oss_reg;

endmodule

>>> hw/rtl/barometric_pressure_compensation.sv
// Top level: sequencer around one shared multiplier and one shared divider
// Each zero divisor skips its division.
// Input is not ready until the result transfers, so items are handled one at a time.
// Each item runs two bit-serial divisions on the shared divider plus the multiply and update steps.
// Reset: coefficients clear, oversampling 3, accumulator 10 << AVERAGE_SHIFT.
`timescale 1ns / 1ps
module barometric_pressure_compensation
    import bpc_pkg::*;
#(
    parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    bpc_in_if.sink   in_ch,
    bpc_out_if.source out_ch,
    bpc_cfg_if.sink  cfg
);

    logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
    logic [1:0]  oss;

    bpc_config u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .ac1_ac2(ac1_ac2), .ac3_ac4(ac3_ac4), .ac5_ac6(ac5_ac6),
        .b1_b2(b1_b2), .mc_md(mc_md), .oss(oss)
    );

    div_req_t dreq;
    div_rsp_t drsp;

    bpc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    seq_state_t state_reg, state_next;

    logic [31:0] ut_reg, up_reg;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        fault_reg, fault_next;
    logic [15:0] temp_reg, temp_next;
    logic [31:0] pval_reg, pval_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] den, t_x3, c_sh, b3_pre, q_x3, b7_sub, divq_s, p8;

    wire [31:0] ac1 = sx16(ac1_ac2[31:16]);
    wire [31:0] ac2 = sx16(ac1_ac2[15:0]);
    wire [31:0] ac3 = sx16(ac3_ac4[31:16]);
    wire [31:0] ac4 = {16'd0, ac3_ac4[15:0]};
    wire [31:0] ac5 = {16'd0, ac5_ac6[31:16]};
    wire [31:0] ac6 = {16'd0, ac5_ac6[15:0]};
    wire [31:0] b1  = sx16(b1_b2[31:16]);
    wire [31:0] b2  = sx16(b1_b2[15:0]);
    wire [31:0] mc  = sx16(mc_md[31:16]);
    wire [31:0] md  = sx16(mc_md[15:0]);

    // Shared 32x32 low-word multiplier, combinational; prod_reg holds a registered copy of the result
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        p8 = $signed(p_reg) >>> 8;
        unique case (state_reg)
            ST_T_MUL:
            begin
                mul_a = ut_reg - ac6;
                mul_b = ac5;
            end
            ST_B6:   begin mul_a = b5_reg - 32'd4000; mul_b = b5_reg - 32'd4000; end
            ST_SQ:   begin mul_a = b2;  mul_b = sq_reg; end
            ST_P_X1: begin mul_a = ac2; mul_b = b6_reg; end
            ST_P_X2: begin mul_a = ac3; mul_b = b6_reg; end
            ST_B3:   begin mul_a = b1;  mul_b = sq_reg; end
            ST_Q_X2: begin mul_a = ac4; mul_b = q_x3 + 32'd32768; end
            ST_B4:   begin mul_a = up_reg - b3_reg; mul_b = 32'd50000 >> oss; end
            ST_C_PP: begin mul_a = p8; mul_b = p8; end
            ST_C_X1: begin mul_a = prod_reg; mul_b = 32'd3038; end
            ST_C_X2: begin mul_a = 32'd0 - 32'd7357; mul_b = p_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign den    = x1_reg + md;
    assign b3_pre = ((ac1 << 2) + x1_reg + x2_reg) << oss;
    assign q_x3   = $signed(x1_reg + x2_reg + 32'd2) >>> 2;
    assign b7_sub = b7_reg;
    assign divq_s = neg_reg ? (32'd0 - drsp.quotient) : drsp.quotient;
    assign t_x3   = x1_reg + x2_reg + 32'd3791;
    assign c_sh   = $signed(t_x3) >>> 4;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (in_ch.valid) state_next = ST_T_MUL;
            ST_T_MUL:       state_next = ST_T_DIV_START;
            ST_T_DIV_START: state_next = (den == 32'd0) ? ST_B6 : ST_T_DIV_WAIT;
            ST_T_DIV_WAIT:  if (drsp.done) state_next = ST_B6;
            ST_B6:          state_next = ST_SQ;
            ST_SQ:          state_next = ST_P_X1;
            ST_P_X1:        state_next = ST_P_X2;
            ST_P_X2:        state_next = ST_B3;
            ST_B3:          state_next = ST_Q_X1;
            ST_Q_X1:        state_next = ST_Q_X2;
            ST_Q_X2:        state_next = ST_B4;
            ST_B4:          state_next = ST_B7;
            ST_B7:          state_next = ST_P_DIV_START;
            ST_P_DIV_START: state_next = (b4_reg == 32'd0) ? ST_C_PP : ST_P_DIV_WAIT;
            ST_P_DIV_WAIT:  if (drsp.done) state_next = ST_C_PP;
            ST_C_PP:        state_next = ST_C_X1;
            ST_C_X1:        state_next = ST_C_X2;
            ST_C_X2:        state_next = ST_DONE;
            ST_DONE:        state_next = ST_OUT;
            ST_OUT:         if (out_ch.ready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Datapath updates per step; x1/x2 are reused scratch registers
    always_comb
    begin
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        b5_next    = b5_reg;
        b6_next    = b6_reg;
        sq_next    = sq_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        b7_next    = b7_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        fault_next = fault_reg;
        temp_next  = temp_reg;
        pval_next  = pval_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        unique case (state_reg)
            ST_IDLE:
                fault_next = 1'b0;
            ST_T_MUL:
                x1_next = $signed(mul_p) >>> 15;
            ST_T_DIV_START:
            begin
                dreq.start    = (den != 32'd0);
                dreq.dividend = mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
                dreq.divisor  = den[31] ? (32'd0 - den) : den;
                neg_next      = mc[31] ^ den[31];
                if (den == 32'd0)
                begin
                    fault_next = 1'b1;
                    b5_next    = x1_reg;
                end
            end
            ST_T_DIV_WAIT:
                if (drsp.done) b5_next = x1_reg + divq_s;
            ST_B6:
            begin
                b6_next   = b5_reg - 32'd4000;
                temp_next = 16'(($signed(b5_reg + 32'd8)) >>> 4);
                sq_next   = $signed(mul_p) >>> 12;
            end
            ST_SQ:
                x1_next = $signed(mul_p) >>> 11;
            ST_P_X1:
                x2_next = $signed(mul_p) >>> 11;
            ST_P_X2:
            begin
                b3_next = $signed(b3_pre + 32'd2) >>> 2;
                x1_next = $signed(mul_p) >>> 13;
            end
            ST_B3:
                x2_next = $signed(mul_p) >>> 16;
            ST_Q_X1: ;
            ST_Q_X2:
                b4_next = mul_p >> 15;
            ST_B4:
                b7_next = mul_p;
            ST_B7: ;
            ST_P_DIV_START:
            begin
                dreq.start    = (b4_reg != 32'd0);
                dreq.dividend = b7_sub[31] ? b7_sub : (b7_sub << 1);
                dreq.divisor  = b4_reg;
                neg_next      = b7_sub[31];
                if (b4_reg == 32'd0)
                begin
                    fault_next = 1'b1;
                    p_next     = '0;
                end
            end
            ST_P_DIV_WAIT:
                if (drsp.done)
                    p_next = neg_reg ? (drsp.quotient << 1) : drsp.quotient;
            ST_C_PP: ;
            ST_C_X1:
                x1_next = $signed(mul_p) >>> 16;
            ST_C_X2:
                x2_next = $signed(mul_p) >>> 16;
            ST_DONE:
            begin
                pval_next = p_reg + c_sh;
                acc_next  = acc_reg - (acc_reg >> AVERAGE_SHIFT) + p_reg + c_sh;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= 32'(10) << AVERAGE_SHIFT;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            ut_reg <= sx16(in_ch.raw_temperature);
            up_reg <= {13'd0, in_ch.raw_pressure};
        end
        prod_reg <= mul_p;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        b5_reg   <= b5_next;
        b6_reg   <= b6_next;
        sq_reg   <= sq_next;
        b3_reg   <= b3_next;
        b4_reg   <= b4_next;
        b7_reg   <= b7_next;
        p_reg    <= p_next;
        neg_reg  <= neg_next;
        temp_reg <= temp_next;
        pval_reg <= pval_next;
    end

    assign in_ch.ready             = (state_reg == ST_IDLE);
    assign out_ch.valid            = (state_reg == ST_OUT);
    assign out_ch.temperature      = temp_reg;
    assign out_ch.pressure         = pval_reg;
    assign out_ch.average_pressure = 27'(acc_reg >> AVERAGE_SHIFT);
    assign out_ch.divide_fault     = fault_reg;

endmodule
